### rtl/bsc_pkg.sv
// Shared types and constants for the barometric sensor compensation pipeline.
package bsc_pkg;

    // Pipeline depth: six stages for the temperature, offset and sensitivity
    // terms and four for the pressure product and saturation.
    localparam int STAGES      = 10;
    localparam int TEMP_STAGES = 6;
    localparam int PRES_STAGES = STAGES - TEMP_STAGES;

    localparam int CFG_INDEX_W = 3;
    localparam int CAL_W       = 16;

    typedef logic [STAGES-1:0] bsc_stage_vec_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_PRESSURE_SENSITIVITY   = 3'd0,
        REG_PRESSURE_OFFSET        = 3'd1,
        REG_SENSITIVITY_TEMP_COEFF = 3'd2,
        REG_OFFSET_TEMP_COEFF      = 3'd3,
        REG_REFERENCE_TEMPERATURE  = 3'd4,
        REG_TEMPERATURE_SLOPE      = 3'd5
    } bsc_reg_idx_t;

    typedef struct packed {
        logic [23:0] raw_pressure;
        logic [23:0] raw_temperature;
    } bsc_sample_t;

    typedef struct packed {
        logic signed [14:0] temperature_centi;
        logic [16:0]        pressure_centi_mbar;
        logic               clamped;
    } bsc_result_t;

    typedef struct packed {
        logic [CAL_W-1:0] pressure_sensitivity;
        logic [CAL_W-1:0] pressure_offset;
        logic [CAL_W-1:0] sensitivity_temp_coeff;
        logic [CAL_W-1:0] offset_temp_coeff;
        logic [CAL_W-1:0] reference_temperature;
        logic [CAL_W-1:0] temperature_slope;
    } bsc_cal_t;

    // Hand-over from the temperature half to the pressure half.
    typedef struct packed {
        logic [23:0]        d1;
        logic signed [18:0] temp;
        logic signed [39:0] off;
        logic signed [39:0] sens;
    } bsc_mid_t;

endpackage

### rtl/bsc_cal_regs.sv
// Calibration word register file with its write channel.
module bsc_cal_regs (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic [bsc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bsc_pkg::CAL_W-1:0]    cfg_data,
    output bsc_pkg::bsc_cal_t            cal
);
    import bsc_pkg::*;

    bsc_cal_t cal_reg;
    bsc_cal_t cal_next;

    always_comb
    begin
        cal_next = cal_reg;
        if (cfg_valid)
        begin
            unique case (bsc_reg_idx_t'(cfg_index))
                REG_PRESSURE_SENSITIVITY:   cal_next.pressure_sensitivity   = cfg_data;
                REG_PRESSURE_OFFSET:        cal_next.pressure_offset        = cfg_data;
                REG_SENSITIVITY_TEMP_COEFF: cal_next.sensitivity_temp_coeff = cfg_data;
                REG_OFFSET_TEMP_COEFF:      cal_next.offset_temp_coeff      = cfg_data;
                REG_REFERENCE_TEMPERATURE:  cal_next.reference_temperature  = cfg_data;
                REG_TEMPERATURE_SLOPE:      cal_next.temperature_slope      = cfg_data;
                default:                    cal_next = cal_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_reg <= '0;
        end
        else
        begin
            cal_reg <= cal_next;
        end
    end

    assign cfg_ready = 1'b1;
    assign cal       = cal_reg;

endmodule

### rtl/bsc_pipe_ctrl.sv
// Stage valid bits and per-stage load enables for the compensation pipeline.
module bsc_pipe_ctrl (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    sample_valid,
    output logic                    sample_ready,
    output logic                    result_valid,
    input  logic                    result_ready,
    output bsc_pkg::bsc_stage_vec_t en
);
    import bsc_pkg::*;

    bsc_stage_vec_t valid_reg;
    bsc_stage_vec_t valid_next;

    // A stage may load when any stage from it downstream is empty, or the
    // result is being taken.
    always_comb
    begin
        for (int k = 0; k < STAGES; k++)
        begin
            en[k] = result_ready || !(&(valid_reg | bsc_stage_vec_t'((1 << k) - 1)));
        end
    end

    always_comb
    begin
        valid_next[0] = en[0] ? sample_valid : valid_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            valid_next[k] = en[k] ? valid_reg[k-1] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign sample_ready = en[0];
    assign result_valid = valid_reg[STAGES-1];

`ifndef SYNTHESIS
    // Occupancy changes only by transactions at the two ends.
    a_occupancy: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ($countones(valid_reg) == $past($countones(valid_reg))
                  + $past(sample_valid && sample_ready)
                  - $past(result_valid && result_ready)))
        else $error("pipeline occupancy lost or gained an item");

    // Input is refused only when every stage is full.
    a_no_bubble_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !sample_ready |-> (&valid_reg))
        else $error("input refused while a bubble is in the pipeline");

    // A held stage keeps its item.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        1'b1 |=> ((valid_reg & ~$past(en)) == ($past(valid_reg) & ~$past(en))))
        else $error("stalled stage dropped or gained an item");
`endif

endmodule

### rtl/bsc_temp_stages.sv
// Stages for dT, first order terms and the second order correction.
module bsc_temp_stages (
    input  logic                               clk,
    input  logic [bsc_pkg::TEMP_STAGES-1:0]    en,
    input  bsc_pkg::bsc_cal_t                  cal,
    input  bsc_pkg::bsc_sample_t               sample,
    output bsc_pkg::bsc_mid_t                  mid
);
    import bsc_pkg::*;

    // stage 0: dT
    logic [23:0]        s0_d1_reg;
    logic signed [24:0] s0_dt_reg;
    logic signed [24:0] s0_dt_next;

    // stage 1: products against dT
    logic [23:0]        s1_d1_reg;
    logic signed [41:0] s1_pc6_reg, s1_pc6_next;
    logic signed [41:0] s1_pc4_reg, s1_pc4_next;
    logic signed [41:0] s1_pc3_reg, s1_pc3_next;
    logic [47:0]        s1_pdd_reg;
    logic signed [49:0] s1_dd_full;

    // stage 2: first order temperature, offset, sensitivity
    logic [23:0]        s2_d1_reg;
    logic signed [17:0] s2_a_reg;
    logic signed [34:0] s2_off_reg, s2_off_next;
    logic signed [33:0] s2_sens_reg, s2_sens_next;
    logic [16:0]        s2_t2_reg;
    logic signed [41:0] s2_pc6_adj, s2_pc4_adj, s2_pc3_adj;

    // stage 3: squares of the temperature distances
    logic [23:0]        s3_d1_reg;
    logic signed [17:0] s3_a_reg;
    logic signed [34:0] s3_off_reg;
    logic signed [33:0] s3_sens_reg;
    logic [16:0]        s3_t2_reg;
    logic [33:0]        s3_sq_reg;
    logic [34:0]        s3_sq2_reg;
    logic               s3_lt20_reg;
    logic               s3_lt15_reg;
    logic signed [18:0] s3_b_next;
    logic signed [35:0] s3_sq_full;
    logic signed [37:0] s3_sq2_full;

    // stage 4: correction terms
    logic [23:0]        s4_d1_reg;
    logic signed [34:0] s4_off_reg;
    logic signed [33:0] s4_sens_reg;
    logic signed [18:0] s4_temp_reg, s4_temp_next;
    logic [37:0]        s4_off2_reg, s4_off2_next;
    logic [37:0]        s4_sens2_reg, s4_sens2_next;
    logic [36:0]        s4_sq_x5;
    logic [37:0]        s4_sq2_x7;
    logic [38:0]        s4_sq2_x11;

    // stage 5: corrected offset and sensitivity
    logic [23:0]        s5_d1_reg;
    logic signed [18:0] s5_temp_reg;
    logic signed [39:0] s5_off_reg, s5_off_next;
    logic signed [39:0] s5_sens_reg, s5_sens_next;

    localparam logic signed [41:0] RND_SLOPE = 42'sd8388607;
    localparam logic signed [41:0] RND_OFF   = 42'sd127;
    localparam logic signed [41:0] RND_SENS  = 42'sd255;
    localparam logic signed [18:0] TEMP_REF  = 19'sd2000;
    localparam logic signed [18:0] LOW_DIST  = 19'sd3500;

    // stage 0
    assign s0_dt_next = $signed({1'b0, sample.raw_temperature})
                      - $signed({1'b0, cal.reference_temperature, 8'd0});

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s0_d1_reg <= sample.raw_pressure;
            s0_dt_reg <= s0_dt_next;
        end
    end

    // stage 1
    assign s1_pc6_next = s0_dt_reg * $signed({1'b0, cal.temperature_slope});
    assign s1_pc4_next = s0_dt_reg * $signed({1'b0, cal.offset_temp_coeff});
    assign s1_pc3_next = s0_dt_reg * $signed({1'b0, cal.sensitivity_temp_coeff});
    assign s1_dd_full  = s0_dt_reg * s0_dt_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s1_d1_reg  <= s0_d1_reg;
            s1_pc6_reg <= s1_pc6_next;
            s1_pc4_reg <= s1_pc4_next;
            s1_pc3_reg <= s1_pc3_next;
            s1_pdd_reg <= s1_dd_full[47:0];
        end
    end

    // stage 2: divisions truncate toward zero, so bias negatives first
    assign s2_pc6_adj = s1_pc6_reg + (s1_pc6_reg[41] ? RND_SLOPE : 42'sd0);
    assign s2_pc4_adj = s1_pc4_reg + (s1_pc4_reg[41] ? RND_OFF : 42'sd0);
    assign s2_pc3_adj = s1_pc3_reg + (s1_pc3_reg[41] ? RND_SENS : 42'sd0);

    assign s2_off_next  = $signed({3'b000, cal.pressure_offset, 16'd0})
                        + $signed(s2_pc4_adj[41:7]);
    assign s2_sens_next = $signed({3'b000, cal.pressure_sensitivity, 15'd0})
                        + $signed(s2_pc3_adj[41:8]);

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s2_d1_reg   <= s1_d1_reg;
            s2_a_reg    <= $signed(s2_pc6_adj[40:23]);
            s2_off_reg  <= s2_off_next;
            s2_sens_reg <= s2_sens_next;
            s2_t2_reg   <= s1_pdd_reg[47:31];
        end
    end

    // stage 3: a = TEMP - 20.00 C, b = TEMP + 15.00 C
    assign s3_b_next   = s2_a_reg + LOW_DIST;
    assign s3_sq_full  = s2_a_reg * s2_a_reg;
    assign s3_sq2_full = s3_b_next * s3_b_next;

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s3_d1_reg   <= s2_d1_reg;
            s3_a_reg    <= s2_a_reg;
            s3_off_reg  <= s2_off_reg;
            s3_sens_reg <= s2_sens_reg;
            s3_t2_reg   <= s2_t2_reg;
            s3_sq_reg   <= s3_sq_full[33:0];
            s3_sq2_reg  <= s3_sq2_full[34:0];
            s3_lt20_reg <= s2_a_reg[17];
            s3_lt15_reg <= s3_b_next[18];
        end
    end

    // stage 4
    assign s4_sq_x5   = {1'b0, s3_sq_reg, 2'b00} + {3'b000, s3_sq_reg};
    assign s4_sq2_x7  = {s3_sq2_reg, 3'b000} - {3'b000, s3_sq2_reg};
    assign s4_sq2_x11 = {1'b0, s3_sq2_reg, 3'b000} + {3'b000, s3_sq2_reg, 1'b0}
                      + {4'b0000, s3_sq2_reg};

    always_comb
    begin
        s4_off2_next  = '0;
        s4_sens2_next = '0;
        if (s3_lt20_reg)
        begin
            s4_off2_next  = {2'b00, s4_sq_x5[36:1]};
            s4_sens2_next = {3'b000, s4_sq_x5[36:2]};
            if (s3_lt15_reg)
            begin
                s4_off2_next  = s4_off2_next + s4_sq2_x7;
                s4_sens2_next = s4_sens2_next + s4_sq2_x11[38:1];
            end
        end
    end

    assign s4_temp_next = s3_a_reg + TEMP_REF
                        - $signed({2'b00, (s3_lt20_reg ? s3_t2_reg : 17'd0)});

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            s4_d1_reg    <= s3_d1_reg;
            s4_off_reg   <= s3_off_reg;
            s4_sens_reg  <= s3_sens_reg;
            s4_temp_reg  <= s4_temp_next;
            s4_off2_reg  <= s4_off2_next;
            s4_sens2_reg <= s4_sens2_next;
        end
    end

    // stage 5
    assign s5_off_next  = s4_off_reg - $signed({2'b00, s4_off2_reg});
    assign s5_sens_next = s4_sens_reg - $signed({2'b00, s4_sens2_reg});

    always_ff @(posedge clk)
    begin
        if (en[5])
        begin
            s5_d1_reg   <= s4_d1_reg;
            s5_temp_reg <= s4_temp_reg;
            s5_off_reg  <= s5_off_next;
            s5_sens_reg <= s5_sens_next;
        end
    end

    assign mid.d1   = s5_d1_reg;
    assign mid.temp = s5_temp_reg;
    assign mid.off  = s5_off_reg;
    assign mid.sens = s5_sens_reg;

endmodule

### rtl/bsc_pres_stages.sv
// Stages for the pressure product, final scaling and saturation.
module bsc_pres_stages (
    input  logic                               clk,
    input  logic [bsc_pkg::PRES_STAGES-1:0]    en,
    input  bsc_pkg::bsc_mid_t                  mid,
    output bsc_pkg::bsc_result_t               result
);
    import bsc_pkg::*;

    // stage 6: D1 * SENS in two partial products
    logic signed [44:0] s6_ph_reg, s6_ph_next;
    logic [43:0]        s6_pl_reg, s6_pl_next;
    logic signed [39:0] s6_off_reg;
    logic signed [18:0] s6_temp_reg;

    // stage 7: full product
    logic signed [63:0] s7_prod_reg, s7_prod_next;
    logic signed [39:0] s7_off_reg;
    logic signed [18:0] s7_temp_reg;

    // stage 8: D1*SENS/2^21 - OFF
    logic signed [63:0] s8_prod_adj;
    logic signed [43:0] s8_diff_reg, s8_diff_next;
    logic signed [18:0] s8_temp_reg;

    // stage 9: /2^15 and saturation
    logic signed [43:0] s9_diff_adj;
    logic signed [28:0] s9_p;
    bsc_result_t        s9_result_reg, s9_result_next;

    localparam logic signed [63:0] RND_PRES_SENS  = 64'sd2097151;
    localparam logic signed [43:0] RND_PRES_FINAL = 44'sd32767;
    localparam logic signed [28:0] PRES_MIN       = 29'sd1000;
    localparam logic signed [28:0] PRES_MAX       = 29'sd120000;
    localparam logic signed [18:0] TEMP_MIN       = -19'sd4000;
    localparam logic signed [18:0] TEMP_MAX       = 19'sd8500;

    // stage 6
    assign s6_ph_next = $signed({1'b0, mid.d1}) * $signed(mid.sens[39:20]);
    assign s6_pl_next = mid.d1 * mid.sens[19:0];

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s6_ph_reg   <= s6_ph_next;
            s6_pl_reg   <= s6_pl_next;
            s6_off_reg  <= mid.off;
            s6_temp_reg <= mid.temp;
        end
    end

    // stage 7: the true product fits in 64 bits, so drop the top bit of ph
    assign s7_prod_next = $signed({s6_ph_reg[43:0], 20'd0} + {20'd0, s6_pl_reg});

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            s7_prod_reg <= s7_prod_next;
            s7_off_reg  <= s6_off_reg;
            s7_temp_reg <= s6_temp_reg;
        end
    end

    // stage 8: truncate toward zero
    assign s8_prod_adj  = s7_prod_reg + (s7_prod_reg[63] ? RND_PRES_SENS : 64'sd0);
    assign s8_diff_next = $signed(s8_prod_adj[63:21]) - s7_off_reg;

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            s8_diff_reg <= s8_diff_next;
            s8_temp_reg <= s7_temp_reg;
        end
    end

    // stage 9
    assign s9_diff_adj = s8_diff_reg + (s8_diff_reg[43] ? RND_PRES_FINAL : 44'sd0);
    assign s9_p        = $signed(s9_diff_adj[43:15]);

    always_comb
    begin
        s9_result_next.clamped = 1'b0;
        if (s8_temp_reg < TEMP_MIN)
        begin
            s9_result_next.temperature_centi = TEMP_MIN[14:0];
            s9_result_next.clamped           = 1'b1;
        end
        else if (s8_temp_reg > TEMP_MAX)
        begin
            s9_result_next.temperature_centi = TEMP_MAX[14:0];
            s9_result_next.clamped           = 1'b1;
        end
        else
        begin
            s9_result_next.temperature_centi = s8_temp_reg[14:0];
        end

        if (s9_p < PRES_MIN)
        begin
            s9_result_next.pressure_centi_mbar = PRES_MIN[16:0];
            s9_result_next.clamped             = 1'b1;
        end
        else if (s9_p > PRES_MAX)
        begin
            s9_result_next.pressure_centi_mbar = PRES_MAX[16:0];
            s9_result_next.clamped             = 1'b1;
        end
        else
        begin
            s9_result_next.pressure_centi_mbar = s9_p[16:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            s9_result_reg <= s9_result_next;
        end
    end

    assign result = s9_result_reg;

endmodule

### rtl/baro_sensor_compensation_unit.sv
// Flow: an accepted sample is registered in stage 0 and then in each later stage up to
//   stage 9, whose register drives the result until the transaction completes.
// Throughput: one sample per cycle through a ten-stage pipeline while results are taken;
//   the two partial products of D1 * SENS and the 64-bit sum behind them set the depth.
// Stalls: a stage holds only while it and every stage after it are full and the
//   result waits, so bubbles close up and input is refused only when all ten are full.
// Reset: rst_n clears the stage valid bits and the six calibration words
//   at once; no clearing pass is needed.
module baro_sensor_compensation_unit (
    input  logic                            clk,
    input  logic                            rst_n,

    input  logic                            sample_valid,
    output logic                            sample_ready,
    input  bsc_pkg::bsc_sample_t            sample,

    output logic                            result_valid,
    input  logic                            result_ready,
    output bsc_pkg::bsc_result_t            result,

    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [bsc_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [bsc_pkg::CAL_W-1:0]       cfg_data
);
    import bsc_pkg::*;

    bsc_cal_t       cal;
    bsc_stage_vec_t stage_en;
    bsc_mid_t       mid;

    // Calibration words; the user must write them only while no transaction is in flight
    // (the block does not enforce this), so every stage may read them directly.
    bsc_cal_regs u_cal_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cal       (cal)
    );

    // Valid bits travel with the data; a stage loads whenever it or some stage
    // after it is empty, or the result is taken.
    bsc_pipe_ctrl u_pipe_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .en           (stage_en)
    );

    // Stages 0..5: dT, first order TEMP/OFF/SENS, squares, the second order
    // correction below 20.00 C and the extra term below -15.00 C.
    bsc_temp_stages u_temp_stages (
        .clk    (clk),
        .en     (stage_en[TEMP_STAGES-1:0]),
        .cal    (cal),
        .sample (sample),
        .mid    (mid)
    );

    // Stages 6..9: D1 * SENS split in two partial products, the 64-bit sum,
    // both truncating divisions and saturation into the output register.
    bsc_pres_stages u_pres_stages (
        .clk    (clk),
        .en     (stage_en[STAGES-1:TEMP_STAGES]),
        .mid    (mid),
        .result (result)
    );

endmodule

### sim/tb_baro_sensor_compensation_unit.sv
// Self-checking testbench for the barometric sensor compensation unit.
`timescale 1ns / 1ps

module tb_baro_sensor_compensation_unit;

    import bsc_pkg::*;

    // Run shape: random phases each load one calibration and then stream readings.
    localparam int RANDOM_PHASES  = 25;
    localparam int PHASE_ITEMS    = 50;
    localparam int CALM_PHASES    = 3;
    localparam int CYCLE_LIMIT    = 500000;
    localparam int DIRECTED_COUNT = 19;

    // Register indexes with no register behind them; writes there must be dropped.
    localparam logic [CFG_INDEX_W-1:0] IDX_SPARE_LO = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] IDX_SPARE_HI = 3'd7;

    // Compensation constants, all carried at 64 bits signed.
    localparam longint TEMP_REF      = 64'sd2000;
    localparam longint TEMP_COLD     = -64'sd1500;
    localparam longint TEMP_MIN      = -64'sd4000;
    localparam longint TEMP_MAX      = 64'sd8500;
    localparam longint PRES_MIN      = 64'sd1000;
    localparam longint PRES_MAX      = 64'sd120000;
    localparam longint SLOPE_DIV     = 64'sd8388608;
    localparam longint T2_DIV        = 64'sd2147483648;
    localparam longint OFF_MUL       = 64'sd65536;
    localparam longint SENS_MUL      = 64'sd32768;
    localparam longint OFF_TC_DIV    = 64'sd128;
    localparam longint SENS_TC_DIV   = 64'sd256;
    localparam longint PRES_SENS_DIV = 64'sd2097152;
    localparam longint PRES_DIV      = 64'sd32768;
    localparam longint REF_SCALE     = 64'sd256;
    localparam longint RAW_MAX       = 64'sd16777215;

    // Typical factory calibration, used as the centre of the realistic random sets.
    localparam logic [15:0] NOMINAL_CAL [6] = '{16'd40127, 16'd36924, 16'd23317,
                                                16'd23282, 16'd33464, 16'd28312};

    // Temperatures that sit on the edges of the second order correction and the range.
    localparam int TEMP_EDGES [6] = '{2000, 1999, -1500, -1501, -4000, 8500};

    // Calibration sets for the directed part, set 0 being the state after reset.
    localparam bsc_cal_t CAL_SETS [6] = '{
        {16'd0,     16'd0,     16'd0,     16'd0,     16'd0,     16'd0    },
        {16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312},
        {16'd65535, 16'd0,     16'd0,     16'd0,     16'd0,     16'd0    },
        {16'd65535, 16'd0,     16'd0,     16'd0,     16'd0,     16'd65535},
        {16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535},
        {16'd0,     16'd0,     16'd0,     16'd0,     16'd65535, 16'd65535}
    };

    typedef struct packed {
        logic [2:0]         cal_set;
        logic               literal_exp;
        logic [23:0]        d1;
        logic [23:0]        d2;
        logic signed [14:0] temp_want;
        logic [16:0]        pres_want;
        logic               clamp_want;
    } directed_row_t;

    // Directed readings. Rows with literal_exp set carry a result that is plain from
    // the equations; the rest go through the predictor.
    localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
        // Unset calibration: zero sensitivity and offset, temperature pinned at 20 C
        '{3'd0, 1'b1, 24'h000000, 24'h000000, 15'sd2000, 17'd1000,   1'b1},
        '{3'd0, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 15'sd2000, 17'd1000,   1'b1},
        '{3'd0, 1'b1, 24'hAAAAAA, 24'h555555, 15'sd2000, 17'd1000,   1'b1},
        '{3'd0, 1'b1, 24'h555555, 24'hAAAAAA, 15'sd2000, 17'd1000,   1'b1},
        // Typical calibration: warm, cold, very cold, raw extremes, dT of zero
        '{3'd1, 1'b0, 24'd9085466, 24'd8569150, 15'sd0, 17'd0, 1'b0},
        '{3'd1, 1'b0, 24'd9085466, 24'd8000000, 15'sd0, 17'd0, 1'b0},
        '{3'd1, 1'b0, 24'd9085466, 24'd7000000, 15'sd0, 17'd0, 1'b0},
        '{3'd1, 1'b0, 24'h000000,  24'h000000,  15'sd0, 17'd0, 1'b0},
        '{3'd1, 1'b0, 24'hFFFFFF,  24'hFFFFFF,  15'sd0, 17'd0, 1'b0},
        '{3'd1, 1'b0, 24'd9085466, 24'd8566784, 15'sd0, 17'd0, 1'b0},
        // Sensitivity only: pressure saturates low with no D1 and high with full D1
        '{3'd2, 1'b1, 24'h000000, 24'h123456, 15'sd2000, 17'd1000,   1'b1},
        '{3'd2, 1'b1, 24'hFFFFFF, 24'h000000, 15'sd2000, 17'd120000, 1'b1},
        // Full slope: temperature saturates high
        '{3'd3, 1'b1, 24'hFFFFFF, 24'hFFFFFF, 15'sd8500, 17'd120000, 1'b1},
        '{3'd3, 1'b1, 24'h000000, 24'h000000, 15'sd2000, 17'd1000,   1'b1},
        // Every word at full scale
        '{3'd4, 1'b0, 24'h000000, 24'h000000, 15'sd0, 17'd0, 1'b0},
        '{3'd4, 1'b0, 24'hFFFFFF, 24'hFFFFFF, 15'sd0, 17'd0, 1'b0},
        '{3'd4, 1'b0, 24'hFFFFFF, 24'h000000, 15'sd0, 17'd0, 1'b0},
        // Deep cold: both second order terms at their largest
        '{3'd5, 1'b0, 24'h000000, 24'h000000, 15'sd0, 17'd0, 1'b0},
        '{3'd5, 1'b0, 24'hFFFFFF, 24'h000000, 15'sd0, 17'd0, 1'b0}
    };

    logic                   clk;
    logic                   rst_n;
    logic                   sample_valid;
    logic                   sample_ready;
    bsc_sample_t            sample;
    logic                   result_valid;
    logic                   result_ready;
    bsc_result_t            result;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CAL_W-1:0]       cfg_data;

    // Calibration as the block holds it, updated on each accepted write transaction.
    bsc_cal_t    cal_shadow;
    // Compensated readings still owed by the block, oldest first.
    bsc_result_t pending_readings [$];

    int  error_count;
    int  cycle_count;
    int  stall_left;
    bit  calm_tail;

    baro_sensor_compensation_unit uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial clk = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clip(input longint v, input longint lo, input longint hi);
        if (v < lo)
        begin
            return lo;
        end
        if (v > hi)
        begin
            return hi;
        end
        return v;
    endfunction

    // First and second order compensation of one conversion pair, 64-bit signed,
    // every division truncating toward zero.
    function automatic bsc_result_t compensate_reading(input bsc_sample_t smp,
                                                       input bsc_cal_t cal);
        longint      d1, d2, c1, c2, c3, c4, c5, c6;
        longint      dt, temp, off_term, sens, t2, off2, sens2, dev, sq, pres;
        bsc_result_t res;
        d1 = longint'({40'd0, smp.raw_pressure});
        d2 = longint'({40'd0, smp.raw_temperature});
        c1 = longint'({48'd0, cal.pressure_sensitivity});
        c2 = longint'({48'd0, cal.pressure_offset});
        c3 = longint'({48'd0, cal.sensitivity_temp_coeff});
        c4 = longint'({48'd0, cal.offset_temp_coeff});
        c5 = longint'({48'd0, cal.reference_temperature});
        c6 = longint'({48'd0, cal.temperature_slope});

        dt       = d2 - c5 * REF_SCALE;
        temp     = TEMP_REF + (dt * c6) / SLOPE_DIV;
        off_term = c2 * OFF_MUL + (c4 * dt) / OFF_TC_DIV;
        sens     = c1 * SENS_MUL + (c3 * dt) / SENS_TC_DIV;
        t2       = 0;
        off2     = 0;
        sens2    = 0;

        // Below 20 C apply the second order terms; below -15 C add the extra ones.
        if (temp < TEMP_REF)
        begin
            dev   = temp - TEMP_REF;
            sq    = dev * dev;
            t2    = (dt * dt) / T2_DIV;
            off2  = (64'sd5 * sq) / 64'sd2;
            sens2 = (64'sd5 * sq) / 64'sd4;
            if (temp < TEMP_COLD)
            begin
                dev   = temp - TEMP_COLD;
                sq    = dev * dev;
                off2  = off2 + 64'sd7 * sq;
                sens2 = sens2 + (64'sd11 * sq) / 64'sd2;
            end
        end
        temp     = temp - t2;
        off_term = off_term - off2;
        sens     = sens - sens2;
        pres     = ((d1 * sens) / PRES_SENS_DIV - off_term) / PRES_DIV;

        res.clamped = (temp < TEMP_MIN) || (temp > TEMP_MAX) ||
                      (pres < PRES_MIN) || (pres > PRES_MAX);
        temp = clip(temp, TEMP_MIN, TEMP_MAX);
        pres = clip(pres, PRES_MIN, PRES_MAX);
        res.temperature_centi   = temp[14:0];
        res.pressure_centi_mbar = pres[16:0];
        return res;
    endfunction

    // Present one reading, optionally after an idle burst, and hold it until the
    // transaction completes. Valid is left high so the next reading can follow at
    // once; callers that pause lower it in the same time step.
    task automatic offer_sample(input bsc_sample_t smp, input bsc_result_t want);
        int gap;
        gap = 0;
        if (!calm_tail && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 15);
        end
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_valid <= 1'b1;
        sample       <= smp;
        do
            @(posedge clk);
        while (!sample_ready);
        pending_readings.push_back(want);
    endtask

    // One write transaction on the calibration port; track it in the shadow copy.
    task automatic write_cal_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_PRESSURE_SENSITIVITY:   cal_shadow.pressure_sensitivity   = data;
            REG_PRESSURE_OFFSET:        cal_shadow.pressure_offset        = data;
            REG_SENSITIVITY_TEMP_COEFF: cal_shadow.sensitivity_temp_coeff = data;
            REG_OFFSET_TEMP_COEFF:      cal_shadow.offset_temp_coeff      = data;
            REG_REFERENCE_TEMPERATURE:  cal_shadow.reference_temperature  = data;
            REG_TEMPERATURE_SLOPE:      cal_shadow.temperature_slope      = data;
            default:                    ;
        endcase
    endtask

    // Drain the pipeline, then load all six words plus one write to an unmapped
    // index, which must leave the calibration untouched.
    task automatic load_calibration(input bsc_cal_t cal);
        sample_valid <= 1'b0;
        while (pending_readings.size() != 0)
        begin
            @(posedge clk);
        end
        write_cal_reg(REG_PRESSURE_SENSITIVITY,   cal.pressure_sensitivity);
        write_cal_reg(REG_PRESSURE_OFFSET,        cal.pressure_offset);
        write_cal_reg(REG_SENSITIVITY_TEMP_COEFF, cal.sensitivity_temp_coeff);
        write_cal_reg(REG_OFFSET_TEMP_COEFF,      cal.offset_temp_coeff);
        write_cal_reg(REG_REFERENCE_TEMPERATURE,  cal.reference_temperature);
        write_cal_reg(REG_TEMPERATURE_SLOPE,      cal.temperature_slope);
        write_cal_reg(($urandom_range(0, 1) != 0) ? IDX_SPARE_HI : IDX_SPARE_LO,
                      16'($urandom));
        cfg_valid <= 1'b0;
    endtask

    // Result side back-pressure: random stalls, none in the tail.
    always @(posedge clk)
    begin
        if (calm_tail)
        begin
            stall_left   <= 0;
            result_ready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            result_ready <= 1'b0;
        end
        else if ($urandom_range(0, 9) == 0)
        begin
            stall_left   <= $urandom_range(0, 14);
            result_ready <= 1'b0;
        end
        else
        begin
            result_ready <= 1'b1;
        end
    end

    // Compare every completed result transaction with the oldest owed reading.
    always @(posedge clk)
    begin : score_result
        bsc_result_t want;
        bsc_result_t got;
        if (rst_n && result_valid && result_ready)
        begin
            got = result;
            if (pending_readings.size() == 0)
            begin
                $error("result with nothing owed: temperature_centi %0d, pressure_centi_mbar %0d",
                       got.temperature_centi, got.pressure_centi_mbar);
                error_count++;
            end
            else
            begin
                want = pending_readings.pop_front();
                if (got.temperature_centi !== want.temperature_centi)
                begin
                    $error("temperature_centi: expected %0d, actual %0d",
                           want.temperature_centi, got.temperature_centi);
                    error_count++;
                end
                if (got.pressure_centi_mbar !== want.pressure_centi_mbar)
                begin
                    $error("pressure_centi_mbar: expected %0d, actual %0d",
                           want.pressure_centi_mbar, got.pressure_centi_mbar);
                    error_count++;
                end
                if (got.clamped !== want.clamped)
                begin
                    $error("clamped: expected %0d, actual %0d", want.clamped, got.clamped);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: a hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb_baro_sensor_compensation_unit failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        directed_row_t row;
        bsc_sample_t   smp;
        bsc_result_t   want;
        bsc_cal_t      cal;
        logic [15:0]   words [6];
        int            active_set;
        int            pick;
        longint        d1, d2, dt, target, jitter;

        error_count = 0;
        cycle_count = 0;
        stall_left  = 0;
        calm_tail   = 1'b0;
        cal_shadow  = '0;

        // Initialise every input of the block and hold reset.
        rst_n        <= 1'b0;
        sample_valid <= 1'b0;
        sample       <= '0;
        result_ready <= 1'b0;
        cfg_valid    <= 1'b0;
        cfg_index    <= '0;
        cfg_data     <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part: walk the table, reloading calibration when the set changes.
        active_set = 0;
        for (int i = 0; i < DIRECTED_COUNT; i++)
        begin
            row = DIRECTED_ROWS[i];
            if (int'(row.cal_set) != active_set)
            begin
                load_calibration(CAL_SETS[row.cal_set]);
                active_set = int'(row.cal_set);
            end
            smp.raw_pressure    = row.d1;
            smp.raw_temperature = row.d2;
            if (row.literal_exp)
            begin
                want = {row.temp_want, row.pres_want, row.clamp_want};
            end
            else
            begin
                want = compensate_reading(smp, cal_shadow);
            end
            offer_sample(smp, want);
        end

        // Random part: one calibration per phase, realistic most of the time.
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase >= RANDOM_PHASES - CALM_PHASES)
            begin
                calm_tail = 1'b1;
            end
            pick = $urandom_range(0, 9);
            for (int w = 0; w < 6; w++)
            begin
                if (pick < 6)
                begin
                    words[w] = NOMINAL_CAL[w] + 16'($urandom_range(0, 8000)) - 16'd4000;
                end
                else if (pick < 8)
                begin
                    words[w] = 16'($urandom);
                end
                else
                begin
                    case ($urandom_range(0, 2))
                        0:       words[w] = 16'h0000;
                        1:       words[w] = 16'hFFFF;
                        default: words[w] = 16'($urandom);
                    endcase
                end
            end
            cal = {words[0], words[1], words[2], words[3], words[4], words[5]};
            load_calibration(cal);

            repeat (PHASE_ITEMS)
            begin
                // D1: full range or a band around a typical sea level reading.
                if ($urandom_range(0, 9) < 4)
                begin
                    d1 = longint'($urandom_range(0, 24'hFFFFFF));
                end
                else
                begin
                    d1 = clip(longint'(9085466 + $urandom_range(0, 4194304)) - 64'sd2097152,
                              0, RAW_MAX);
                end

                // D2: full range, or steered at a target temperature so the second
                // order thresholds and the range edges are crossed often.
                if ($urandom_range(0, 9) < 3)
                begin
                    d2 = longint'($urandom_range(0, 24'hFFFFFF));
                end
                else
                begin
                    if ($urandom_range(0, 6) == 0)
                    begin
                        target = longint'(TEMP_EDGES[$urandom_range(0, 5)]);
                    end
                    else
                    begin
                        target = longint'(int'($urandom_range(0, 14000)) - 5000);
                    end
                    jitter = longint'(int'($urandom_range(0, 64)) - 32);
                    if (cal_shadow.temperature_slope == 16'd0)
                    begin
                        dt = jitter;
                    end
                    else
                    begin
                        dt = ((target - TEMP_REF) * SLOPE_DIV) /
                             longint'({48'd0, cal_shadow.temperature_slope}) + jitter;
                    end
                    d2 = clip(longint'({48'd0, cal_shadow.reference_temperature}) * REF_SCALE
                              + dt, 0, RAW_MAX);
                end

                smp.raw_pressure    = d1[23:0];
                smp.raw_temperature = d2[23:0];
                offer_sample(smp, compensate_reading(smp, cal_shadow));
            end
        end

        // Drop valid, let every owed reading arrive, then watch a little longer for
        // anything spurious.
        sample_valid <= 1'b0;
        calm_tail = 1'b1;
        while (pending_readings.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (2 * STAGES) @(posedge clk);

        if (error_count == 0)
        begin
            $display("tb_baro_sensor_compensation_unit passed");
        end
        else
        begin
            $display("tb_baro_sensor_compensation_unit failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/bsc_pkg.sv
rtl/bsc_cal_regs.sv
rtl/bsc_pipe_ctrl.sv
rtl/bsc_temp_stages.sv
rtl/bsc_pres_stages.sv
rtl/baro_sensor_compensation_unit.sv
sim/tb_baro_sensor_compensation_unit.sv
